FILE: rtl/rdc_pkg.sv
`timescale 1ns / 1ps
package rdc_pkg;

    // Sizes of the stores
    localparam int ARRAY_DEPTH = 1024;
    localparam int VALUE_RANGE = 4096;
    localparam int LOG_DEPTH   = 1024;

    // Field widths
    localparam int POS_W = 11;
    localparam int VAL_W = 12;
    localparam int CNT_W = 11;
    localparam int CMD_W = 2;

    // Derived address widths
    localparam int AW  = $clog2(ARRAY_DEPTH);
    localparam int LAW = $clog2(LOG_DEPTH);
    localparam int VAW = $clog2(VALUE_RANGE);
    localparam int LOG_W = AW + VAL_W;

    localparam logic [POS_W-1:0] ARRAY_TOP = POS_W'(ARRAY_DEPTH);
    localparam logic [POS_W-1:0] LOG_TOP   = POS_W'(LOG_DEPTH);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    // Request to the count unit: read, adjust by one, write back
    typedef struct packed {
        logic             valid;
        logic             inc;
        logic [VAL_W-1:0] val;
    } cnt_req_t;

endpackage

FILE: rtl/range_distinct_count_with_updates_core.sv
`timescale 1ns / 1ps
// Loads outside the window, appends and ignored beats finish in the idle state.
// A load inside the window reads the old element, then counts the old value out and
// the new one in. A query moves the window ends step by step, then applies or undoes
// logged updates one by one, counting only those inside the window; an empty range
// skips the steps. A result waits in an output register; the next beat is taken
// meanwhile; a later query holds until then. Reset clears the counts with in_ready low.
module range_distinct_count_with_updates_core
    import rdc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [CMD_W-1:0] cmd,
    input  logic [POS_W-1:0] position,
    input  logic [VAL_W-1:0] item_value,
    input  logic [POS_W-1:0] range_left,
    input  logic [POS_W-1:0] range_right,
    input  logic [POS_W-1:0] updates_applied,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [CNT_W-1:0] distinct_count
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_STEP  = 9'b000000010,
        ST_MOVE  = 9'b000000100,
        ST_LOAD  = 9'b000001000,
        ST_LOGRD = 9'b000010000,
        ST_TOGSW = 9'b000100000,
        ST_CRD   = 9'b001000000,
        ST_CWR   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [POS_W-1:0] ws_reg, ws_next, we_reg, we_next;
    logic [POS_W-1:0] ta_reg, ta_next, total_reg, total_next;
    logic [POS_W-1:0] lo_reg, lo_next, hi_reg, hi_next, t_reg, t_next;
    logic             empty_reg, empty_next;
    logic             ret_idle_reg, ret_idle_next;
    logic             two_reg, two_next, idx_reg, idx_next;
    logic [VAL_W-1:0] op_val_reg [2];
    logic [VAL_W-1:0] op_val_next [2];
    logic             op_inc_reg [2];
    logic             op_inc_next [2];
    logic             move_inc_reg, move_inc_next;
    logic [LAW-1:0]   log_idx_reg, log_idx_next;
    logic [AW-1:0]    log_pos_reg, log_pos_next;
    logic [VAL_W-1:0] log_val_reg, log_val_next;
    logic [VAL_W-1:0] load_val_reg, load_val_next;
    logic [AW-1:0]    load_idx_reg, load_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] result_reg, result_next;

    logic [VAL_W-1:0] elem_mem [ARRAY_DEPTH];
    logic [VAL_W-1:0] elem_rdata_reg;
    logic [AW-1:0]    elem_raddr;
    logic             elem_we;
    logic [AW-1:0]    elem_waddr;
    logic [VAL_W-1:0] elem_wdata;

    logic [LOG_W-1:0] log_mem [LOG_DEPTH];
    logic [LOG_W-1:0] log_rdata_reg;
    logic [LAW-1:0]   log_raddr;
    logic             log_we;
    logic [LAW-1:0]   log_waddr;
    logic [LOG_W-1:0] log_wdata;

    cnt_req_t         cnt_req;
    logic             cnt_ready;
    logic [CNT_W-1:0] cnt_distinct;

    logic             accept;
    logic             pos_ok;
    logic             load_in_win;
    logic [POS_W-1:0] lo_c, hi_c, t_c;
    logic [POS_W-1:0] tog_pos;

    rdc_count_unit u_count (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (cnt_req),
        .ready    (cnt_ready),
        .distinct (cnt_distinct)
    );

    assign in_ready       = (state_reg == ST_IDLE) && cnt_ready;
    assign accept         = in_valid && in_ready;
    assign out_valid      = out_valid_reg;
    assign distinct_count = result_reg;

    assign pos_ok = (position != '0) && (position <= ARRAY_TOP)
                    && (int'(item_value) < VALUE_RANGE);
    assign load_in_win = (position >= ws_reg) && (position <= we_reg);
    assign lo_c = (range_left == '0) ? POS_W'(1) : range_left;
    assign hi_c = (range_right > ARRAY_TOP) ? ARRAY_TOP : range_right;
    assign t_c  = (updates_applied > total_reg) ? total_reg : updates_applied;
    assign tog_pos = {1'b0, log_pos_reg} + POS_W'(1);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        ws_next        = ws_reg;
        we_next        = we_reg;
        ta_next        = ta_reg;
        total_next     = total_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        t_next         = t_reg;
        empty_next     = empty_reg;
        ret_idle_next  = ret_idle_reg;
        two_next       = two_reg;
        idx_next       = idx_reg;
        op_val_next    = op_val_reg;
        op_inc_next    = op_inc_reg;
        move_inc_next  = move_inc_reg;
        log_idx_next   = log_idx_reg;
        log_pos_next   = log_pos_reg;
        log_val_next   = log_val_reg;
        load_val_next  = load_val_reg;
        load_idx_next  = load_idx_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;

        elem_raddr = ws_reg[AW-1:0];
        elem_we    = 1'b0;
        elem_waddr = load_idx_reg;
        elem_wdata = load_val_reg;
        log_raddr  = log_idx_reg;
        log_we     = 1'b0;
        log_waddr  = total_reg[LAW-1:0];
        log_wdata  = {load_idx_reg, load_val_reg};
        cnt_req    = '0;

        // Drop the result once its beat is taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_LOAD:
                        begin
                            if (pos_ok)
                            begin
                                if (load_in_win)
                                begin
                                    elem_raddr    = AW'(position - POS_W'(1));
                                    load_idx_next = AW'(position - POS_W'(1));
                                    load_val_next = item_value;
                                    state_next    = ST_LOAD;
                                end
                                else
                                begin
                                    elem_we    = 1'b1;
                                    elem_waddr = AW'(position - POS_W'(1));
                                    elem_wdata = item_value;
                                end
                            end
                        end
                        CMD_UPDATE:
                        begin
                            if (pos_ok && (total_reg < LOG_TOP))
                            begin
                                log_we     = 1'b1;
                                log_waddr  = total_reg[LAW-1:0];
                                log_wdata  = {AW'(position - POS_W'(1)), item_value};
                                total_next = total_reg + POS_W'(1);
                            end
                        end
                        CMD_QUERY:
                        begin
                            lo_next = lo_c;
                            hi_next = hi_c;
                            t_next  = t_c;
                            if (hi_c < lo_c)
                            begin
                                empty_next = 1'b1;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                empty_next = 1'b0;
                                state_next = ST_STEP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                // Old element out, new one in, then write the element
                op_val_next[0] = elem_rdata_reg;
                op_inc_next[0] = 1'b0;
                op_val_next[1] = load_val_reg;
                op_inc_next[1] = 1'b1;
                two_next       = 1'b1;
                idx_next       = 1'b0;
                ret_idle_next  = 1'b1;
                elem_we        = 1'b1;
                elem_waddr     = load_idx_reg;
                elem_wdata     = load_val_reg;
                state_next     = ST_CRD;
            end
            ST_STEP:
            begin
                ret_idle_next = 1'b0;
                if (ws_reg > lo_reg)
                begin
                    elem_raddr    = AW'(ws_reg - POS_W'(2));
                    ws_next       = ws_reg - POS_W'(1);
                    move_inc_next = 1'b1;
                    state_next    = ST_MOVE;
                end
                else if (we_reg < hi_reg)
                begin
                    elem_raddr    = we_reg[AW-1:0];
                    we_next       = we_reg + POS_W'(1);
                    move_inc_next = 1'b1;
                    state_next    = ST_MOVE;
                end
                else if (ws_reg < lo_reg)
                begin
                    elem_raddr    = AW'(ws_reg - POS_W'(1));
                    ws_next       = ws_reg + POS_W'(1);
                    move_inc_next = 1'b0;
                    state_next    = ST_MOVE;
                end
                else if (we_reg > hi_reg)
                begin
                    elem_raddr    = AW'(we_reg - POS_W'(1));
                    we_next       = we_reg - POS_W'(1);
                    move_inc_next = 1'b0;
                    state_next    = ST_MOVE;
                end
                else if (ta_reg < t_reg)
                begin
                    log_raddr    = ta_reg[LAW-1:0];
                    log_idx_next = ta_reg[LAW-1:0];
                    ta_next      = ta_reg + POS_W'(1);
                    state_next   = ST_LOGRD;
                end
                else if (ta_reg > t_reg)
                begin
                    log_raddr    = LAW'(ta_reg - POS_W'(1));
                    log_idx_next = LAW'(ta_reg - POS_W'(1));
                    ta_next      = ta_reg - POS_W'(1);
                    state_next   = ST_LOGRD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MOVE:
            begin
                op_val_next[0] = elem_rdata_reg;
                op_inc_next[0] = move_inc_reg;
                two_next       = 1'b0;
                idx_next       = 1'b0;
                state_next     = ST_CRD;
            end
            ST_LOGRD:
            begin
                // Latch the log entry and fetch the element it names
                log_pos_next = log_rdata_reg[LOG_W-1:VAL_W];
                log_val_next = log_rdata_reg[VAL_W-1:0];
                elem_raddr   = log_rdata_reg[LOG_W-1:VAL_W];
                state_next   = ST_TOGSW;
            end
            ST_TOGSW:
            begin
                // Swap the logged value with the element
                elem_we    = 1'b1;
                elem_waddr = log_pos_reg;
                elem_wdata = log_val_reg;
                log_we     = 1'b1;
                log_waddr  = log_idx_reg;
                log_wdata  = {log_pos_reg, elem_rdata_reg};
                if ((tog_pos >= ws_reg) && (tog_pos <= we_reg))
                begin
                    op_val_next[0] = log_val_reg;
                    op_inc_next[0] = 1'b1;
                    op_val_next[1] = elem_rdata_reg;
                    op_inc_next[1] = 1'b0;
                    two_next       = 1'b1;
                    idx_next       = 1'b0;
                    state_next     = ST_CRD;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_CRD:
            begin
                cnt_req.valid = 1'b1;
                cnt_req.inc   = op_inc_reg[idx_reg];
                cnt_req.val   = op_val_reg[idx_reg];
                state_next    = ST_CWR;
            end
            ST_CWR:
            begin
                if (two_reg && !idx_reg)
                begin
                    idx_next   = 1'b1;
                    state_next = ST_CRD;
                end
                else if (ret_idle_reg)
                    state_next = ST_IDLE;
                else
                    state_next = ST_STEP;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    result_next    = empty_reg ? '0 : cnt_distinct;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Element and log memories
    always_ff @(posedge clk)
    begin
        if (elem_we)
            elem_mem[elem_waddr] <= elem_wdata;
        elem_rdata_reg <= elem_mem[elem_raddr];
        if (log_we)
            log_mem[log_waddr] <= log_wdata;
        log_rdata_reg <= log_mem[log_raddr];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        t_reg        <= t_next;
        empty_reg    <= empty_next;
        two_reg      <= two_next;
        idx_reg      <= idx_next;
        op_val_reg   <= op_val_next;
        op_inc_reg   <= op_inc_next;
        move_inc_reg <= move_inc_next;
        log_idx_reg  <= log_idx_next;
        log_pos_reg  <= log_pos_next;
        log_val_reg  <= log_val_next;
        load_val_reg <= load_val_next;
        load_idx_reg <= load_idx_next;
        result_reg   <= result_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ws_reg        <= POS_W'(1);
            we_reg        <= '0;
            ta_reg        <= '0;
            total_reg     <= '0;
            ret_idle_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ws_reg        <= ws_next;
            we_reg        <= we_next;
            ta_reg        <= ta_next;
            total_reg     <= total_next;
            ret_idle_reg  <= ret_idle_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/rdc_count_unit.sv
`timescale 1ns / 1ps
module rdc_count_unit
    import rdc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cnt_req_t         req,
    output logic             ready,
    output logic [CNT_W-1:0] distinct
);

    logic [CNT_W-1:0] mem [VALUE_RANGE];
    logic [CNT_W-1:0] rdata_reg;
    logic [VAW:0]     clr_idx_reg;
    logic             wr_reg;
    logic             inc_reg;
    logic [VAW-1:0]   addr_reg;
    logic [CNT_W-1:0] distinct_reg;
    logic [CNT_W-1:0] new_cnt;
    logic [CNT_W-1:0] distinct_next;
    logic             clearing;

    assign clearing = !clr_idx_reg[VAW];
    assign ready    = !clearing;
    assign distinct = distinct_reg;

    // Work out the adjusted count and the distinct total
    always_comb
    begin
        new_cnt       = rdata_reg;
        distinct_next = distinct_reg;
        if (inc_reg)
        begin
            new_cnt = rdata_reg + CNT_W'(1);
            if (rdata_reg == '0)
                distinct_next = distinct_reg + CNT_W'(1);
        end
        else if (rdata_reg != '0)
        begin
            new_cnt = rdata_reg - CNT_W'(1);
            if (rdata_reg == CNT_W'(1))
                distinct_next = distinct_reg - CNT_W'(1);
        end
    end

    // Count memory: clearing sweep, then read-modify-write
    always_ff @(posedge clk)
    begin
        if (clearing)
            mem[clr_idx_reg[VAW-1:0]] <= '0;
        else if (wr_reg)
            mem[addr_reg] <= new_cnt;
        rdata_reg <= mem[req.val[VAW-1:0]];
    end

    // Hold the pending write
    always_ff @(posedge clk)
    begin
        addr_reg <= req.val[VAW-1:0];
        inc_reg  <= req.inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            wr_reg       <= 1'b0;
            distinct_reg <= '0;
        end
        else
        begin
            if (clearing)
                clr_idx_reg <= clr_idx_reg + (VAW+1)'(1);
            wr_reg <= req.valid;
            if (wr_reg)
                distinct_reg <= distinct_next;
        end
    end

endmodule

FILE: rtl/rdc_checker.sv
`timescale 1ns / 1ps
module rdc_checker
    import rdc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic [CMD_W-1:0] cmd,
    input logic             out_valid,
    input logic             out_ready,
    input logic [CNT_W-1:0] distinct_count
);

    // Hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distinct_count))
        else $error("stalled result beat changed");

    // A count never exceeds the array depth
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distinct_count <= CNT_W'(ARRAY_DEPTH))
        else $error("distinct count above array depth");

    // A query beat takes in_ready low in the cycle after it
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && cmd == CMD_QUERY |=> !in_ready)
        else $error("query beat did not stop intake");

endmodule

bind range_distinct_count_with_updates_core rdc_checker u_rdc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .distinct_count (distinct_count)
);

FILE: tb/range_distinct_count_checker.sv
`timescale 1ns / 1ps
module range_distinct_count_checker
    import rdc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [CMD_W-1:0] cmd,
    input  logic [POS_W-1:0] position,
    input  logic [VAL_W-1:0] item_value,
    input  logic [POS_W-1:0] range_left,
    input  logic [POS_W-1:0] range_right,
    input  logic [POS_W-1:0] updates_applied,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [CNT_W-1:0] distinct_count,
    output int               error_count,
    output int               pending
);

    // Shadow copy of the block's stores
    logic [VAL_W-1:0] elements [1:ARRAY_DEPTH];
    int               tally [VALUE_RANGE];
    logic [POS_W-1:0] log_pos [LOG_DEPTH];
    logic [VAL_W-1:0] log_val [LOG_DEPTH];
    int               log_count;
    int               win_lo;
    int               win_hi;
    int               time_now;
    int               distinct_now;

    logic [CNT_W-1:0] expected_counts [$];

    function automatic void tally_add(logic [VAL_W-1:0] v);
        tally[v]++;
        if (tally[v] == 1)
            distinct_now++;
    endfunction

    function automatic void tally_drop(logic [VAL_W-1:0] v);
        if (tally[v] == 0)
            return;
        tally[v]--;
        if (tally[v] == 0)
            distinct_now--;
    endfunction

    // Swap a logged value with the stored element; works both ways
    function automatic void swap_update(int idx);
        int               p;
        logic [VAL_W-1:0] held;
        p = log_pos[idx];
        if (p >= win_lo && p <= win_hi)
        begin
            tally_add(log_val[idx]);
            tally_drop(elements[p]);
        end
        held         = log_val[idx];
        log_val[idx] = elements[p];
        elements[p]  = held;
    endfunction

    // Move the window and update time, return the distinct count
    function automatic logic [CNT_W-1:0] predict_count(int lo, int hi, int t);
        if (lo < 1)
            lo = 1;
        if (hi > ARRAY_DEPTH)
            hi = ARRAY_DEPTH;
        if (t > log_count)
            t = log_count;
        if (hi < lo)
            return '0;
        while (win_lo > lo)
        begin
            win_lo--;
            tally_add(elements[win_lo]);
        end
        while (win_hi < hi)
        begin
            win_hi++;
            tally_add(elements[win_hi]);
        end
        while (win_lo < lo)
        begin
            tally_drop(elements[win_lo]);
            win_lo++;
        end
        while (win_hi > hi)
        begin
            tally_drop(elements[win_hi]);
            win_hi--;
        end
        while (time_now < t)
        begin
            swap_update(time_now);
            time_now++;
        end
        while (time_now > t)
        begin
            time_now--;
            swap_update(time_now);
        end
        return CNT_W'(distinct_now);
    endfunction

    // Clear the shadow state in reset; predict on each input beat, compare on
    // each result beat
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VALUE_RANGE; i++)
                tally[i] = 0;
            log_count    = 0;
            win_lo       = 1;
            win_hi       = 0;
            time_now     = 0;
            distinct_now = 0;
            error_count  = 0;
            pending      = 0;
            expected_counts.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, distinct_count);
                    error_count++;
                end
                else
                begin
                    if (distinct_count !== expected_counts[0])
                    begin
                        $display("%0t: distinct_count mismatch, expected %0d, actual %0d",
                                 $time, expected_counts[0], distinct_count);
                        error_count++;
                    end
                    void'(expected_counts.pop_front());
                end
            end
            if (in_valid && in_ready)
            begin
                if ((cmd == CMD_LOAD || cmd == CMD_UPDATE) && position >= 1
                    && position <= ARRAY_TOP)
                begin
                    if (cmd == CMD_LOAD)
                    begin
                        if (position >= win_lo && position <= win_hi)
                        begin
                            tally_drop(elements[position]);
                            tally_add(item_value);
                        end
                        elements[position] = item_value;
                    end
                    else if (log_count < LOG_DEPTH)
                    begin
                        log_pos[log_count] = position;
                        log_val[log_count] = item_value;
                        log_count++;
                    end
                end
                else if (cmd == CMD_QUERY)
                    expected_counts.insert(expected_counts.size(),
                                           predict_count(range_left, range_right,
                                                         updates_applied));
            end
            pending = expected_counts.size();
        end
    end

endmodule

FILE: tb/range_distinct_count_with_updates_core_tb.sv
`timescale 1ns / 1ps
module range_distinct_count_with_updates_core_tb;
    import rdc_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] item_value;
    logic [POS_W-1:0] range_left;
    logic [POS_W-1:0] range_right;
    logic [POS_W-1:0] updates_applied;
    logic             out_valid;
    logic             out_ready;
    logic [CNT_W-1:0] distinct_count;
    int               error_count;
    int               pending;

    // Stimulus bookkeeping: positions 1..loaded_top are written
    int loaded_top;
    int logged;
    bit quiet;
    bit long_hold;
    bit hold_done;
    int cycles;

    range_distinct_count_with_updates_core dut (.*);

    range_distinct_count_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Bound the run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        hold_done  = 1'b0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Offer one beat and hold it until taken, then maybe idle
    task automatic send_beat(logic [CMD_W-1:0] c, int p, int v, int lo, int hi, int t);
        in_valid        <= 1'b1;
        cmd             <= c;
        position        <= POS_W'(p);
        item_value      <= VAL_W'(v);
        range_left      <= POS_W'(lo);
        range_right     <= POS_W'(hi);
        updates_applied <= POS_W'(t);
        do
            @(posedge clk);
        while (!in_ready);
        if (c == CMD_LOAD && p == loaded_top + 1)
            loaded_top++;
        if (c == CMD_UPDATE && p >= 1 && p <= ARRAY_DEPTH && logged < LOG_DEPTH)
            logged++;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic random_query();
        int lo;
        int hi;
        lo = $urandom_range(1, loaded_top);
        hi = $urandom_range(lo, loaded_top);
        if ($urandom_range(0, 9) == 0)
            lo = 0;
        send_beat(CMD_QUERY, $urandom_range(0, 2047), $urandom, lo, hi,
                  $urandom_range(0, logged + 3));
    endtask

    initial
    begin
        int r;
        int p;
        in_valid        = 1'b0;
        cmd             = CMD_LOAD;
        position        = '0;
        item_value      = '0;
        range_left      = '0;
        range_right     = '0;
        updates_applied = '0;
        loaded_top      = 0;
        logged          = 0;
        quiet           = 1'b0;
        long_hold       = 1'b0;
        rst_n           = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extreme values, bad positions, clamps, empty ranges
        for (int i = 1; i <= 8; i++)
            send_beat(CMD_LOAD, i, (i % 2) ? 4095 : 0, 0, 0, 0);
        send_beat(CMD_LOAD, 0, 7, 0, 0, 0);
        send_beat(CMD_LOAD, 2047, 7, 0, 0, 0);
        send_beat(CMD_UPDATE, 0, 5, 0, 0, 0);
        send_beat(CMD_UPDATE, 1025, 5, 0, 0, 0);
        send_beat(CMD_QUERY, 0, 0, 1, 8, 0);
        send_beat(CMD_UPDATE, 2, 4095, 0, 0, 0);
        send_beat(CMD_UPDATE, 3, 17, 0, 0, 0);
        send_beat(CMD_QUERY, 0, 0, 0, 8, 2047);
        send_beat(CMD_LOAD, 4, 17, 0, 0, 0);
        send_beat(CMD_QUERY, 0, 0, 2, 5, 1);
        send_beat(CMD_QUERY, 0, 0, 5, 3, 2);
        send_beat(CMD_QUERY, 0, 0, 2047, 1500, 0);
        send_beat(CMD_RESERVED, 2047, 4095, 2047, 2047, 2047);
        send_beat(CMD_QUERY, 0, 0, 1, 1, 0);
        send_beat(CMD_QUERY, 0, 0, 8, 8, 2);

        // Random: mostly valid traffic over the written prefix, some noise
        for (int n = 0; n < 620; n++)
        begin
            if (n == 300)
                long_hold = 1'b1;
            if (n == 540)
                quiet = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 18)
            begin
                if (loaded_top < ARRAY_DEPTH && $urandom_range(0, 1) == 0)
                    p = loaded_top + 1;
                else
                    p = $urandom_range(1, loaded_top);
                send_beat(CMD_LOAD, p, ($urandom_range(0, 1) == 0) ?
                          $urandom_range(0, 31) : $urandom_range(0, 4095), 0, 0, 0);
            end
            else if (r < 30 && logged < 900)
                send_beat(CMD_UPDATE, $urandom_range(1, loaded_top),
                          $urandom_range(0, 40), 0, 0, 0);
            else if (r < 88)
                random_query();
            else if (r < 93)
                send_beat(CMD_W'($urandom_range(0, 1)), ($urandom_range(0, 1) == 0) ? 0 :
                          $urandom_range(1025, 2047), $urandom, $urandom, $urandom, $urandom);
            else if (r < 96)
                send_beat(CMD_RESERVED, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                send_beat(CMD_QUERY, 0, 0, $urandom_range(2, 2047),
                          $urandom_range(0, 1), $urandom);
        end

        // Query at both ends of time, with the update count clamped
        for (int i = 0; i < 3; i++)
            send_beat(CMD_UPDATE, 1, 9, 0, 0, 0);
        send_beat(CMD_QUERY, 0, 0, 1, loaded_top, 1024);
        send_beat(CMD_QUERY, 0, 0, 1, loaded_top, 0);
        send_beat(CMD_QUERY, 0, 0, 1, loaded_top, 2047);
        random_query();
        in_valid <= 1'b0;

        // Drain, then allow the block to settle
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (error_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
